### design/bresenham_line_rasterizer_top_macros.svh
// Assertion macros shared by the rasterizer modules.
// No dependencies; files that assert include this header.
`ifndef BRESENHAM_LINE_RASTERIZER_TOP_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BLR_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BLR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/blr_pkg.sv
// Types and constants of the line rasterizer.
// No dependencies; used by all rasterizer modules.
package blr_pkg;

  localparam int unsigned CoordBits = 10;
  // Error spans +-2*(2^CoordBits - 1): two bits above the coordinate.
  localparam int unsigned ErrBits   = CoordBits + 2;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueIdxBits = $clog2(QueueDepth);
  localparam int unsigned QueueCntBits = $clog2(QueueDepth + 1);

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic signed [ErrBits-1:0] err_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_e;

  typedef struct packed {
    action_e action;
    coord_t  start_x;
    coord_t  start_y;
    coord_t  finish_x;
    coord_t  finish_y;
  } in_item_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } out_item_t;

  // Classified item as it travels from front to back.
  typedef struct packed {
    action_e action;
    coord_t  pos_x;
    coord_t  pos_y;
    coord_t  delta_major;
    coord_t  delta_minor;
    err_t    error_init;
    logic    minor_neg;
    logic    steep;
  } cmd_t;

  // Queue status seen by the back end; its full flag drives the top-level full port.
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

### design/bresenham_line_rasterizer_top.sv
// Line rasterizer top level: front setup, command queue and pixel back end.
// Depends on blr_pkg, blr_front, blr_cmd_queue and blr_back.
//
// Items go in through a queue-style port (push/full) and pixels come out
// through another (empty/pop). A load item carries two endpoints, produces no
// pixel and is set up by the combinational front end; a step item yields one
// pixel of the current line (both endpoints included, the final one marked by
// last_pixel) or nothing when no line is active. The back end does one error
// add-compare-update per cycle, so the block sustains one item per clock while
// the receiver keeps popping. A step item's pixel goes through the command
// queue and then the output register before it reaches the output ports.
// A two-entry command queue and the output register decouple both sides.
module bresenham_line_rasterizer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  blr_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output blr_pkg::out_item_t out_item_o
);

  blr_pkg::cmd_t      front_cmd, queue_cmd;
  blr_pkg::q_status_t q_status;
  logic               cmd_take;

  blr_front u_front (
    .in_item_i (in_item_i),
    .cmd_o     (front_cmd)
  );

  blr_cmd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (push),
    .wr_cmd_i (front_cmd),
    .rd_en_i  (cmd_take),
    .rd_cmd_o (queue_cmd),
    .status_o (q_status)
  );

  blr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (queue_cmd),
    .q_status_i (q_status),
    .cmd_take_o (cmd_take),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  assign full = q_status.full;

endmodule

### design/blr_front.sv
// Front end: classifies an incoming item and does the line setup for loads.
// Depends on blr_pkg.
module blr_front (
  input  blr_pkg::in_item_t in_item_i,
  output blr_pkg::cmd_t     cmd_o
);

  blr_pkg::coord_t adx, ady, sx, sy, ex, ey;
  logic            steep, swap;

  always_comb begin
    adx   = (in_item_i.start_x > in_item_i.finish_x) ?
            in_item_i.start_x - in_item_i.finish_x :
            in_item_i.finish_x - in_item_i.start_x;
    ady   = (in_item_i.start_y > in_item_i.finish_y) ?
            in_item_i.start_y - in_item_i.finish_y :
            in_item_i.finish_y - in_item_i.start_y;
    steep = ady > adx;
    // major coordinate must count up
    swap  = steep ? (in_item_i.start_y > in_item_i.finish_y) :
                    (in_item_i.start_x > in_item_i.finish_x);
    sx    = swap ? in_item_i.finish_x : in_item_i.start_x;
    sy    = swap ? in_item_i.finish_y : in_item_i.start_y;
    ex    = swap ? in_item_i.start_x  : in_item_i.finish_x;
    ey    = swap ? in_item_i.start_y  : in_item_i.finish_y;

    cmd_o.action      = in_item_i.action;
    cmd_o.pos_x       = sx;
    cmd_o.pos_y       = sy;
    cmd_o.steep       = steep;
    cmd_o.delta_major = steep ? ady : adx;
    cmd_o.delta_minor = steep ? adx : ady;
    cmd_o.minor_neg   = steep ? (ex < sx) : (ey < sy);
    cmd_o.error_init  = blr_pkg::err_t'({1'b0, cmd_o.delta_minor, 1'b0})
                      - blr_pkg::err_t'({2'b00, cmd_o.delta_major});
  end

endmodule

### design/blr_cmd_queue.sv
// Short queue between front and back so that each side stalls on its own.
// Depends on blr_pkg.
module blr_cmd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  blr_pkg::cmd_t      wr_cmd_i,
  input  logic               rd_en_i,
  output blr_pkg::cmd_t      rd_cmd_o,
  output blr_pkg::q_status_t status_o
);

  blr_pkg::cmd_t mem_q [blr_pkg::QueueDepth];
  logic [blr_pkg::QueueIdxBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [blr_pkg::QueueCntBits-1:0] count_q, count_d;
  logic do_wr, do_rd;

  assign status_o.full  = count_q == blr_pkg::QueueCntBits'(blr_pkg::QueueDepth);
  assign status_o.valid = count_q != '0;
  assign do_wr = wr_en_i && !status_o.full;
  assign do_rd = rd_en_i && status_o.valid;
  assign rd_cmd_o = mem_q[rd_ptr_q];

  // depth is a power of two, so pointers wrap naturally
  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

### design/blr_back.sv
// Back end: line state, per-pixel error update and the result register.
// Depends on blr_pkg and the assertion macro header.
`include "bresenham_line_rasterizer_top_macros.svh"

module blr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  blr_pkg::cmd_t      cmd_i,
  input  blr_pkg::q_status_t q_status_i,
  output logic               cmd_take_o,
  output logic               empty,
  input  logic               pop,
  output blr_pkg::out_item_t out_item_o
);

  blr_pkg::coord_t pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  blr_pkg::coord_t dmaj_q, dmaj_d, dmin_q, dmin_d, steps_q, steps_d;
  blr_pkg::err_t   err_q, err_d, err_mid, dmaj2, dmin2;
  logic            neg_q, neg_d, steep_q, steep_d, busy_q, busy_d;
  logic            out_valid_q, out_valid_d, out_ready, is_step, emit, err_pos;
  blr_pkg::out_item_t out_q, out_d;
  blr_pkg::coord_t minor_cur, minor_next;

  assign out_ready  = !out_valid_q || pop;
  assign cmd_take_o = q_status_i.valid && out_ready;
  assign is_step    = cmd_i.action == blr_pkg::ACT_STEP;
  assign emit       = cmd_take_o && is_step && busy_q;
  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

  assign dmaj2   = blr_pkg::err_t'({1'b0, dmaj_q, 1'b0});
  assign dmin2   = blr_pkg::err_t'({1'b0, dmin_q, 1'b0});
  assign err_pos = !err_q[blr_pkg::ErrBits-1] && (err_q != '0);

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    dmaj_d  = dmaj_q;
    dmin_d  = dmin_q;
    steps_d = steps_q;
    err_d   = err_q;
    neg_d   = neg_q;
    steep_d = steep_q;
    busy_d  = busy_q;
    out_d   = out_q;
    out_valid_d = out_valid_q && !pop;

    minor_cur  = steep_q ? pos_x_q : pos_y_q;
    minor_next = neg_q ? minor_cur - 1'b1 : minor_cur + 1'b1;
    err_mid    = err_pos ? err_q - dmaj2 : err_q;

    if (cmd_take_o && !is_step) begin
      pos_x_d = cmd_i.pos_x;
      pos_y_d = cmd_i.pos_y;
      dmaj_d  = cmd_i.delta_major;
      dmin_d  = cmd_i.delta_minor;
      steps_d = cmd_i.delta_major;
      err_d   = cmd_i.error_init;
      neg_d   = cmd_i.minor_neg;
      steep_d = cmd_i.steep;
      busy_d  = 1'b1;
    end else if (emit) begin
      out_d.pixel_x    = pos_x_q;
      out_d.pixel_y    = pos_y_q;
      out_d.last_pixel = steps_q == '0;
      out_valid_d      = 1'b1;
      if (steps_q == '0) begin
        busy_d = 1'b0;
      end else begin
        steps_d = steps_q - 1'b1;
        err_d   = err_mid + dmin2;
        if (steep_q) begin
          pos_y_d = pos_y_q + 1'b1;
          if (err_pos) begin
            pos_x_d = minor_next;
          end
        end else begin
          pos_x_d = pos_x_q + 1'b1;
          if (err_pos) begin
            pos_y_d = minor_next;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      dmaj_q      <= '0;
      dmin_q      <= '0;
      steps_q     <= '0;
      err_q       <= '0;
      neg_q       <= 1'b0;
      steep_q     <= 1'b0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      dmaj_q      <= dmaj_d;
      dmin_q      <= dmin_d;
      steps_q     <= steps_d;
      err_q       <= err_d;
      neg_q       <= neg_d;
      steep_q     <= steep_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  `BLR_ASSERT_IMPLIES(a_steps_bound, clk_i, rst_ni, busy_q, steps_q <= dmaj_q, "steps exceed major delta")
  `BLR_ASSERT_IMPLIES(a_err_bound, clk_i, rst_ni, busy_q, err_q <= dmin2, "error term above 2*minor delta")
  `BLR_ASSERT_IMPLIES(a_idle_steps, clk_i, rst_ni, !busy_q, steps_q == '0, "idle with steps pending")
  `BLR_ASSERT_NEXT(a_last_ends, clk_i, rst_ni, emit && (steps_q == '0), !busy_q, "still busy after last pixel")

endmodule

### verif/tb.sv
// Self-checking testbench for bresenham_line_rasterizer_top: line loads and pixel steps
// are pushed with random gaps, and each pixel is checked against an in-bench Bresenham model.
// Depends on blr_pkg and the rasterizer RTL.
module tb;
  import blr_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int RandomItems   = 1040;
  localparam int DrainCycles   = 10;
  localparam int HoldCycles    = 300;

  // Tracks the line state and holds the pixels that the block still owes.
  class pixel_scoreboard;
    out_item_t         owed_pixels[$];
    int                mismatches;
    coord_t            cur_x, cur_y;
    coord_t            d_major, d_minor;
    logic signed [12:0] err;
    logic [10:0]       pixels_left;
    logic              minor_neg, steep, active;

    function new();
      mismatches  = 0;
      cur_x       = '0;
      cur_y       = '0;
      d_major     = '0;
      d_minor     = '0;
      err         = '0;
      pixels_left = '0;
      minor_neg   = 1'b0;
      steep       = 1'b0;
      active      = 1'b0;
    endfunction

    function void note_item(in_item_t it);
      coord_t    ax, ay, bx, by, adx, ady;
      out_item_t px;
      if (it.action == ACT_LOAD) begin
        ax  = it.start_x;
        ay  = it.start_y;
        bx  = it.finish_x;
        by  = it.finish_y;
        adx = (ax > bx) ? ax - bx : bx - ax;
        ady = (ay > by) ? ay - by : by - ay;
        steep = ady > adx;
        // order endpoints so the major coordinate counts up
        if ((!steep && ax > bx) || (steep && ay > by)) begin
          {ax, bx} = {bx, ax};
          {ay, by} = {by, ay};
        end
        d_major   = steep ? ady : adx;
        d_minor   = steep ? adx : ady;
        minor_neg = steep ? (bx < ax) : (by < ay);
        cur_x     = ax;
        cur_y     = ay;
        err       = $signed({2'b00, d_minor, 1'b0}) - $signed({3'b000, d_major});
        pixels_left = {1'b0, d_major};
        active    = 1'b1;
      end else if (active) begin
        px.pixel_x    = cur_x;
        px.pixel_y    = cur_y;
        px.last_pixel = (pixels_left == 0);
        owed_pixels.push_back(px);
        if (pixels_left == 0) begin
          active = 1'b0;
        end else begin
          pixels_left--;
          if (steep) cur_y++;
          else cur_x++;
          if (err > 13'sd0) begin
            if (steep) cur_x = minor_neg ? cur_x - 1'b1 : cur_x + 1'b1;
            else cur_y = minor_neg ? cur_y - 1'b1 : cur_y + 1'b1;
            err = err - $signed({2'b00, d_major, 1'b0});
          end
          err = err + $signed({2'b00, d_minor, 1'b0});
        end
      end
    endfunction

    function void check_pixel(out_item_t got);
      out_item_t want;
      if (owed_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel x=%0d y=%0d last=%0b",
                   got.pixel_x, got.pixel_y, got.last_pixel);
        return;
      end
      want = owed_pixels.pop_front();
      if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
          got.last_pixel !== want.last_pixel) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel mismatch: exp x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                   want.pixel_x, want.pixel_y, want.last_pixel,
                   got.pixel_x, got.pixel_y, got.last_pixel);
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_item = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_item;

  pixel_scoreboard sb = new();

  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit rx_hold_req = 1'b0;
  int idle_cycles = 0;
  int useful_items = 0;

  always #4 clk_i = ~clk_i;

  bresenham_line_rasterizer_top uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item)
  );

  // mostly short gaps, a few long ones
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
    sb.note_item(it);
  endtask

  function automatic in_item_t step_item();
    in_item_t it;
    it.action   = ACT_STEP;
    it.start_x  = coord_t'($urandom);
    it.start_y  = coord_t'($urandom);
    it.finish_x = coord_t'($urandom);
    it.finish_y = coord_t'($urandom);
    return it;
  endfunction

  function automatic int line_len(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
    int adx, ady;
    adx = (x0 > x1) ? x0 - x1 : x1 - x0;
    ady = (y0 > y1) ? y0 - y1 : y1 - y0;
    return ((adx > ady) ? adx : ady) + 1;
  endfunction

  // load a line, then issue n_steps steps (fewer than its length abandons it)
  task automatic run_line(coord_t x0, coord_t y0, coord_t x1, coord_t y1, int n_steps);
    in_item_t it;
    int len;
    it.action   = ACT_LOAD;
    it.start_x  = x0;
    it.start_y  = y0;
    it.finish_x = x1;
    it.finish_y = y1;
    send_item(it);
    repeat (n_steps) send_item(step_item());
    len = line_len(x0, y0, x1, y1);
    useful_items += 1 + ((n_steps < len) ? n_steps : len);
  endtask

  function automatic coord_t near_coord(coord_t c);
    int v, off;
    off = $urandom_range(0, 24);
    v = int'(c) + off - 12;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return coord_t'(v);
  endfunction

  function automatic coord_t anchor_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return coord_t'($urandom);
  endfunction

  // receiver: random pop gaps, plus one long hold on request
  initial begin
    int rx_stall;
    rx_stall = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else if (rx_stall > 0) begin
        pop <= 1'b0;
        rx_stall--;
      end else begin
        pop <= 1'b1;
        rx_stall = pick_gap(rx_calm);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_pixel(out_item);
    if (rst_ni && ((push && !full) || (pop && !empty))) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("[bresenham_line_rasterizer_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    coord_t x0, y0, x1, y1;
    int r, len, target;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle step, single-pixel lines, reversed and steep lines, 45 degrees,
    // loads that abandon a line in progress, full-range corners
    send_item(step_item());
    run_line(10'd5, 10'd5, 10'd5, 10'd5, 2);
    run_line(10'd1023, 10'd1023, 10'd1023, 10'd1023, 1);
    run_line(10'd5, 10'd9, 10'd3, 10'd9, 3);
    run_line(10'd512, 10'd3, 10'd512, 10'd1, 3);
    run_line(10'd1023, 10'd0, 10'd1021, 10'd2, 3);
    run_line(10'd2, 10'd0, 10'd0, 10'd5, 2);
    run_line(10'd0, 10'd1023, 10'd1023, 10'd0, 3);
    run_line(10'd1023, 10'd1023, 10'd0, 10'd0, 2);

    // fill the block while the receiver holds off
    rx_hold_req = 1'b1;
    tx_calm = 1'b1;
    run_line(10'd0, 10'd5, 10'd900, 10'd300, 80);
    tx_calm = 1'b0;

    target = useful_items + RandomItems;
    while (useful_items < target) begin
      if ($urandom_range(0, 15) == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // noise: stray items of either kind
        repeat ($urandom_range(1, 4)) begin
          in_item_t it;
          it = step_item();
          it.action = action_e'($urandom_range(0, 1));
          send_item(it);
          useful_items++;
        end
      end else if (r < 16) begin
        x0 = coord_t'($urandom);
        y0 = coord_t'($urandom);
        x1 = coord_t'($urandom);
        y1 = coord_t'($urandom);
        run_line(x0, y0, x1, y1, $urandom_range(5, 40));
      end else begin
        x0 = anchor_coord();
        y0 = anchor_coord();
        x1 = near_coord(x0);
        y1 = near_coord(y0);
        len = line_len(x0, y0, x1, y1);
        r = $urandom_range(0, 9);
        if (r == 0) len = len + $urandom_range(1, 3);
        else if (r == 1) len = $urandom_range(0, len - 1);
        run_line(x0, y0, x1, y1, len);
      end
    end
    push <= 1'b0;
    rx_calm = 1'b0;

    while (sb.owed_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.owed_pixels.size() == 0)
      $display("[bresenham_line_rasterizer_top] OK");
    else
      $display("[bresenham_line_rasterizer_top] ERROR");
    $finish;
  end

endmodule
